[rtl/ria_pkg.sv]
`default_nettype none
package ria_pkg;

   // Block sizing.
   localparam int NUM_REQUESTERS = 16;
   localparam int NUM_RESOURCES  = 8;
   localparam int INSTANCES      = 10;

   // Derived widths.
   localparam int REQ_W   = $clog2(NUM_REQUESTERS);
   localparam int RES_W   = $clog2(NUM_RESOURCES);
   localparam int ADDR_W  = REQ_W + RES_W;
   localparam int DEPTH   = NUM_REQUESTERS * NUM_RESOURCES;
   localparam int FREE_W  = $clog2(INSTANCES + 1);
   localparam int WAIT_W  = 8;
   localparam logic [WAIT_W-1:0] WAIT_MAX = '1;

   // Operation codes.
   localparam logic [1:0] OP_REQUEST   = 2'd0;
   localparam logic [1:0] OP_RELEASE   = 2'd1;
   localparam logic [1:0] OP_TERMINATE = 2'd2;

   // Result status codes.
   localparam logic [2:0] ST_GRANTED    = 3'd0;
   localparam logic [2:0] ST_WAITING    = 3'd1;
   localparam logic [2:0] ST_RELEASED   = 3'd2;
   localparam logic [2:0] ST_IGNORED    = 3'd3;
   localparam logic [2:0] ST_TERMINATED = 3'd4;

   // Controller states.
   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_EXEC,
      S_WALK,
      S_DRAIN,
      S_RESP
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic exec;
      logic walk_rd;
      logic term_clear;
      logic load_rsp;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic walk_last;
      logic out_free;
   } stat_type;

endpackage
`default_nettype wire

[rtl/ria_ctrl.sv]
`default_nettype none
module ria_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic [1:0]       req_operation,
   output logic                  req_ready,
   input  wire ria_pkg::stat_type stat,
   output ria_pkg::cmd_type      cmd
);
   import ria_pkg::*;

   state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = (req_operation == OP_TERMINATE) ? S_WALK : S_READ;
            end
         end
         S_READ:  state_in = S_EXEC;
         S_EXEC:  state_in = S_RESP;
         S_WALK: begin
            if (stat.walk_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: state_in = S_RESP;
         S_RESP: begin
            if (stat.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         S_READ:  ;
         S_EXEC:  cmd.exec = 1'b1;
         S_WALK:  cmd.walk_rd = 1'b1;
         S_DRAIN: cmd.term_clear = 1'b1;
         S_RESP:  cmd.load_rsp = stat.out_free;
         default: ;
      endcase
   end

endmodule
`default_nettype wire

[rtl/ria_dp.sv]
`default_nettype none
module ria_dp (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire ria_pkg::cmd_type cmd,
   output ria_pkg::stat_type     stat,
   input  wire logic [1:0]       req_operation,
   input  wire logic [3:0]       req_requester_id,
   input  wire logic [2:0]       req_class_id,
   input  wire logic             rsp_ready,
   output logic                  rsp_valid,
   output logic [2:0]            rsp_status,
   output logic [3:0]            rsp_requester_out,
   output logic [3:0]            rsp_available_after
);
   import ria_pkg::*;

   // Captured item.
   logic [1:0]          op_ff;
   logic [3:0]          rid_ff;
   logic [2:0]          res_ff;

   // Terminate walk.
   logic [RES_W-1:0]    walk_ff;
   logic                pend_ff;
   logic [RES_W-1:0]    rd_res_ff;

   // Count stores and their read data.
   logic [FREE_W-1:0]   held_mem_ff [DEPTH];
   logic [WAIT_W-1:0]   wait_mem_ff [DEPTH];
   logic [FREE_W-1:0]   held_q_ff;
   logic [WAIT_W-1:0]   wait_q_ff;
   logic                hvld_q_ff;
   logic                wvld_q_ff;
   logic [DEPTH-1:0]    held_vld_ff;
   logic [DEPTH-1:0]    wait_vld_ff;

   logic [FREE_W-1:0]   free_ff [NUM_RESOURCES];
   logic [FREE_W-1:0]   free_in [NUM_RESOURCES];
   logic [2:0]          stat_ff, stat_in;

   // Result register.
   logic                rsp_valid_ff;
   logic [2:0]          rsp_status_ff;
   logic [3:0]          rsp_rid_ff;
   logic [3:0]          rsp_avail_ff;

   logic [REQ_W-1:0]    who;
   logic [RES_W-1:0]    res_idx;
   logic [RES_W-1:0]    rd_res;
   logic [ADDR_W-1:0]   rd_addr;
   logic [ADDR_W-1:0]   wr_addr;
   logic                res_ok;
   logic [FREE_W-1:0]   held_eff;
   logic [WAIT_W-1:0]   wait_eff;
   logic                held_we, wait_we;
   logic [FREE_W-1:0]   held_wd;
   logic [WAIT_W-1:0]   wait_wd;

   // Addressing: the requester slot selects a row, the resource a column.
   assign who     = rid_ff[REQ_W-1:0];
   assign res_idx = res_ff[RES_W-1:0];
   assign res_ok  = (32'(res_ff) < NUM_RESOURCES);
   assign rd_res  = cmd.walk_rd ? walk_ff : res_idx;
   assign rd_addr = {who, rd_res};
   assign wr_addr = {who, res_idx};

   // Entries never written since reset or terminate read as zero.
   assign held_eff = hvld_q_ff ? held_q_ff : '0;
   assign wait_eff = wvld_q_ff ? wait_q_ff : '0;

   // Capture the accepted beat.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= req_operation;
         rid_ff <= req_requester_id;
         res_ff <= req_class_id;
      end
   end

   // Walk counter over the resource classes for a terminate.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= 1'b0;
      end else begin
         pend_ff <= cmd.walk_rd;
      end
      if (cmd.capture) begin
         walk_ff <= '0;
      end else if (cmd.walk_rd) begin
         walk_ff <= walk_ff + 1'b1;
      end
      rd_res_ff <= rd_res;
   end

   assign stat.walk_last = (walk_ff == RES_W'(NUM_RESOURCES - 1));

   // Held and waiting count memories with registered read data.
   always_ff @(posedge clock) begin
      if (held_we) begin
         held_mem_ff[wr_addr] <= held_wd;
      end
      held_q_ff <= held_mem_ff[rd_addr];
      hvld_q_ff <= held_vld_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (wait_we) begin
         wait_mem_ff[wr_addr] <= wait_wd;
      end
      wait_q_ff <= wait_mem_ff[rd_addr];
      wvld_q_ff <= wait_vld_ff[rd_addr];
   end

   // Valid bits: set on write, cleared for a whole row on terminate.
   always_ff @(posedge clock) begin
      if (reset) begin
         held_vld_ff <= '0;
         wait_vld_ff <= '0;
      end else begin
         if (held_we) begin
            held_vld_ff[wr_addr] <= 1'b1;
         end
         if (wait_we) begin
            wait_vld_ff[wr_addr] <= 1'b1;
         end
         if (cmd.term_clear) begin
            for (int r = 0; r < NUM_RESOURCES; r++) begin
               held_vld_ff[{who, RES_W'(r)}] <= 1'b0;
               wait_vld_ff[{who, RES_W'(r)}] <= 1'b0;
            end
         end
      end
   end

   // Request and release updates, and the terminate give-back.
   always_comb begin
      held_we = 1'b0;
      wait_we = 1'b0;
      held_wd = held_eff;
      wait_wd = wait_eff;
      free_in = free_ff;
      stat_in = stat_ff;
      if (cmd.exec) begin
         case (op_ff)
            OP_REQUEST: begin
               if (!res_ok) begin
                  stat_in = ST_WAITING;
               end else if (free_ff[res_idx] != '0) begin
                  free_in[res_idx] = free_ff[res_idx] - 1'b1;
                  held_we = 1'b1;
                  held_wd = held_eff + 1'b1;
                  stat_in = ST_GRANTED;
               end else begin
                  wait_we = 1'b1;
                  if (wait_eff != WAIT_MAX) begin
                     wait_wd = wait_eff + 1'b1;
                  end
                  stat_in = ST_WAITING;
               end
            end
            OP_RELEASE: begin
               if (res_ok && held_eff != '0) begin
                  held_we = 1'b1;
                  held_wd = held_eff - 1'b1;
                  free_in[res_idx] = free_ff[res_idx] + 1'b1;
                  stat_in = ST_RELEASED;
               end else begin
                  stat_in = ST_IGNORED;
               end
            end
            default: stat_in = ST_IGNORED;
         endcase
      end
      if (pend_ff) begin
         free_in[rd_res_ff] = free_ff[rd_res_ff] + held_eff;
      end
   end

   // Free counts per resource class.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < NUM_RESOURCES; r++) begin
            free_ff[r] <= FREE_W'(INSTANCES);
         end
      end else begin
         free_ff <= free_in;
      end
      stat_ff <= stat_in;
   end

   // Result register; a new beat loads once the previous one is taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.load_rsp) begin
         rsp_status_ff <= (op_ff == OP_TERMINATE) ? ST_TERMINATED : stat_ff;
         rsp_rid_ff    <= rid_ff;
         rsp_avail_ff  <= res_ok ? 4'(free_ff[res_idx]) : 4'd0;
      end
   end

   assign stat.out_free       = !rsp_valid_ff || rsp_ready;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_requester_out   = rsp_rid_ff;
   assign rsp_available_after = rsp_avail_ff;

endmodule
`default_nettype wire

[rtl/resource_instance_allocator.sv]
`default_nettype none
// Resource instance allocator.
// Requests enter on the req_ channel (operation, requester_id, class_id)
// with a valid/ready handshake; each accepted beat yields exactly one beat on
// the rsp_ channel (status, requester_out, available_after).
// Items are processed one at a time. A request or release goes through a
// count memory read, an update and a load of the result register.
// A terminate walks every resource class through the single read port of
// the held-count memory, one class per cycle, before its result is loaded.
// After the result is loaded the block returns to idle and can accept the
// next beat even if the receiver has not taken it yet; the result register
// holds it stable.
// If the receiver stalls with a result still waiting, the next item finishes
// its work and then waits until the register frees; req_ready stays low.
// Synchronous reset sets every free count to the full instance count and
// clears all held and waiting counts at once; no clearing pass is needed.
module resource_instance_allocator (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [1:0] req_operation,
   input  wire logic [3:0] req_requester_id,
   input  wire logic [2:0] req_class_id,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [2:0]      rsp_status,
   output logic [3:0]      rsp_requester_out,
   output logic [3:0]      rsp_available_after
);
   import ria_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // Sequencer.
   ria_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_ready     (req_ready),
      .stat          (stat),
      .cmd           (cmd)
   );

   // Counts, memories and result register.
   ria_dp u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_operation       (req_operation),
      .req_requester_id    (req_requester_id),
      .req_class_id        (req_class_id),
      .rsp_ready           (rsp_ready),
      .rsp_valid           (rsp_valid),
      .rsp_status          (rsp_status),
      .rsp_requester_out   (rsp_requester_out),
      .rsp_available_after (rsp_available_after)
   );

endmodule
`default_nettype wire
